### hdl/gpma_pkg.sv
// shared types and constants for the grid path to motion actions block
// no dependencies; used by every module under hdl
package gpma_pkg;

    localparam int CoordBits   = 10;
    localparam int HalfBits    = CoordBits + 1;
    localparam int TimeBits    = 32;
    localparam int NumBits     = 32;
    localparam int RobotBits   = 10;
    localparam int HeadBits    = 2;
    localparam int CfgIdxBits  = 1;
    localparam int FifoDepth   = 4;
    localparam int FifoPtrBits = $clog2(FifoDepth);
    localparam int FifoCntBits = $clog2(FifoDepth + 1);

    // configuration register indexes
    localparam logic [CfgIdxBits-1:0] CfgFlipAxes  = 1'b0;
    localparam logic [CfgIdxBits-1:0] CfgTimedMode = 1'b1;

    // action kinds
    localparam logic KindTurn = 1'b0;
    localparam logic KindMove = 1'b1;

    // raw heading codes
    localparam logic [HeadBits-1:0] HeadXDown = 2'd0;
    localparam logic [HeadBits-1:0] HeadYUp   = 2'd1;
    localparam logic [HeadBits-1:0] HeadXUp   = 2'd2;
    localparam logic [HeadBits-1:0] HeadYDown = 2'd3;

    typedef enum logic {
        CMD_STEP,
        CMD_BAD
    } t_cmd_kind;

    typedef enum logic [1:0] {
        PH_TURN,
        PH_MOVE1,
        PH_MOVE2,
        PH_BAD
    } t_phase;

    typedef struct packed {
        logic flip_axes;
        logic timed_mode;
    } t_cfg;

    // one classified waypoint handed from front to back
    typedef struct packed {
        t_cmd_kind             kind;
        logic                  turn;
        logic [RobotBits-1:0]  robot;
        logic [HeadBits-1:0]   heading;
        logic [CoordBits-1:0]  prev_x;
        logic [CoordBits-1:0]  prev_y;
        logic [CoordBits-1:0]  cell_x;
        logic [CoordBits-1:0]  cell_y;
        logic [TimeBits-1:0]   prev_time;
    } t_cmd;

    typedef struct packed {
        logic [RobotBits-1:0] robot;
        logic                 kind;
        logic [HeadBits-1:0]  heading;
        logic [HalfBits-1:0]  from_x;
        logic [HalfBits-1:0]  from_y;
        logic [HalfBits-1:0]  to_x;
        logic [HalfBits-1:0]  to_y;
        logic [TimeBits-1:0]  start_time;
        logic [NumBits-1:0]   action_number;
        logic                 bad_move;
        logic                 last;
    } t_result;

endpackage

### hdl/gpma_front.sv
// front end: configuration registers, tracking state of the current agent, waypoint classification
// depends on gpma_pkg; feeds commands into gpma_cmd_fifo
module gpma_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [gpma_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic                           i_cfg_data,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [gpma_pkg::CoordBits-1:0] i_cell_x,
    input  logic [gpma_pkg::CoordBits-1:0] i_cell_y,
    input  logic                           i_starts_agent,
    input  logic [gpma_pkg::RobotBits-1:0] i_agent_id,
    input  logic [gpma_pkg::TimeBits-1:0]  i_stamp,
    output gpma_pkg::t_cfg                 o_cfg,
    output logic                           o_wr_en,
    output gpma_pkg::t_cmd                 o_wr_cmd
);

    gpma_pkg::t_cfg                  r_cfg, n_cfg;
    logic [gpma_pkg::CoordBits-1:0]  r_prev_x, n_prev_x;
    logic [gpma_pkg::CoordBits-1:0]  r_prev_y, n_prev_y;
    logic [gpma_pkg::HeadBits-1:0]   r_heading, n_heading;
    logic [gpma_pkg::TimeBits-1:0]   r_prev_time, n_prev_time;
    logic                            r_failed, n_failed;

    logic                            accept;
    logic [gpma_pkg::CoordBits-1:0]  dx, dy;
    logic [gpma_pkg::CoordBits:0]    manhattan;
    logic [gpma_pkg::TimeBits-1:0]   new_time;
    logic [gpma_pkg::HeadBits-1:0]   raw_need, need;

    assign accept = i_push && !i_full;
    assign o_cfg  = r_cfg;

    // configuration writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gpma_pkg::CfgFlipAxes:  n_cfg.flip_axes  = i_cfg_data;
                gpma_pkg::CfgTimedMode: n_cfg.timed_mode = i_cfg_data;
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    // distance and wanted heading
    always_comb begin
        dx        = (i_cell_x > r_prev_x) ? i_cell_x - r_prev_x : r_prev_x - i_cell_x;
        dy        = (i_cell_y > r_prev_y) ? i_cell_y - r_prev_y : r_prev_y - i_cell_y;
        manhattan = {1'b0, dx} + {1'b0, dy};
        new_time  = r_cfg.timed_mode ? i_stamp : r_prev_time + 1'b1;
        if (dx == '0) begin
            raw_need = (i_cell_y > r_prev_y) ? gpma_pkg::HeadYUp : gpma_pkg::HeadYDown;
        end else begin
            raw_need = (i_cell_x > r_prev_x) ? gpma_pkg::HeadXUp : gpma_pkg::HeadXDown;
        end
        need = r_cfg.flip_axes ? raw_need : ~raw_need;
    end

    // classify the word and update tracking state
    always_comb begin
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_heading   = r_heading;
        n_prev_time = r_prev_time;
        n_failed    = r_failed;
        o_wr_en     = 1'b0;

        o_wr_cmd.kind      = gpma_pkg::CMD_STEP;
        o_wr_cmd.turn      = (need != r_heading);
        o_wr_cmd.robot     = i_agent_id;
        o_wr_cmd.heading   = need;
        o_wr_cmd.prev_x    = r_prev_x;
        o_wr_cmd.prev_y    = r_prev_y;
        o_wr_cmd.cell_x    = i_cell_x;
        o_wr_cmd.cell_y    = i_cell_y;
        o_wr_cmd.prev_time = r_prev_time;

        if (accept) begin
            priority if (i_starts_agent) begin
                n_prev_x    = i_cell_x;
                n_prev_y    = i_cell_y;
                n_heading   = '0;
                n_prev_time = r_cfg.timed_mode ? i_stamp : '0;
                n_failed    = 1'b0;
            end else if (r_failed) begin
                n_failed = 1'b1;
            end else if (manhattan >= 2) begin
                o_wr_en       = 1'b1;
                o_wr_cmd.kind = gpma_pkg::CMD_BAD;
                n_failed      = 1'b1;
            end else if (manhattan == '0) begin
                n_prev_time = new_time;
            end else begin
                o_wr_en     = 1'b1;
                n_prev_x    = i_cell_x;
                n_prev_y    = i_cell_y;
                n_heading   = need;
                n_prev_time = new_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_heading   <= '0;
            r_prev_time <= '0;
            r_failed    <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_heading   <= n_heading;
            r_prev_time <= n_prev_time;
            r_failed    <= n_failed;
        end
    end

endmodule

### hdl/gpma_cmd_fifo.sv
// short command queue between front and back
// depends on gpma_pkg for the command type and depth
module gpma_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  gpma_pkg::t_cmd i_wr_cmd,
    output logic           o_full,
    input  logic           i_rd_en,
    output gpma_pkg::t_cmd o_rd_cmd,
    output logic           o_empty
);

    gpma_pkg::t_cmd                   r_mem [gpma_pkg::FifoDepth];
    logic [gpma_pkg::FifoPtrBits-1:0] r_wr_ptr, n_wr_ptr;
    logic [gpma_pkg::FifoPtrBits-1:0] r_rd_ptr, n_rd_ptr;
    logic [gpma_pkg::FifoCntBits-1:0] r_count, n_count;
    logic                             do_wr, do_rd;

    assign o_full   = (r_count == gpma_pkg::FifoCntBits'(gpma_pkg::FifoDepth));
    assign o_empty  = (r_count == '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];
    assign do_wr    = i_wr_en && !o_full;
    assign do_rd    = i_rd_en && !o_empty;

    // pointer and fill level
    always_comb begin
        n_wr_ptr = do_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

### hdl/gpma_back.sv
// back end: expands each command into turn and move words or a bad-move word, numbers actions
// depends on gpma_pkg; reads from gpma_cmd_fifo and drives the result register
module gpma_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gpma_pkg::t_cfg    i_cfg,
    input  logic              i_fifo_empty,
    input  gpma_pkg::t_cmd    i_fifo_cmd,
    output logic              o_fifo_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output gpma_pkg::t_result o_result
);

    gpma_pkg::t_cmd     r_cmd, n_cmd;
    logic               r_cmd_valid, n_cmd_valid;
    gpma_pkg::t_phase   r_phase, n_phase;
    gpma_pkg::t_result  r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [gpma_pkg::NumBits-1:0] r_count, n_count;

    logic               pop_ok, out_load, last_phase, cmd_done, load_cmd;
    gpma_pkg::t_result  res;
    logic [gpma_pkg::HalfBits-1:0] ax, ay, bx, by;
    logic [gpma_pkg::HalfBits-1:0] prev2_x, prev2_y, mid_x, mid_y, cell2_x, cell2_y;

    assign pop_ok     = i_pop && r_out_valid;
    assign out_load   = r_cmd_valid && (!r_out_valid || pop_ok);
    assign last_phase = (r_phase == gpma_pkg::PH_MOVE2) || (r_phase == gpma_pkg::PH_BAD);
    assign cmd_done   = out_load && last_phase;
    assign load_cmd   = (!r_cmd_valid || cmd_done) && !i_fifo_empty;
    assign o_fifo_rd  = load_cmd;
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    // sequencer next state
    always_comb begin
        n_cmd       = r_cmd;
        n_cmd_valid = r_cmd_valid;
        n_phase     = r_phase;
        if (load_cmd) begin
            n_cmd       = i_fifo_cmd;
            n_cmd_valid = 1'b1;
            if (i_fifo_cmd.kind == gpma_pkg::CMD_BAD) begin
                n_phase = gpma_pkg::PH_BAD;
            end else if (i_fifo_cmd.turn) begin
                n_phase = gpma_pkg::PH_TURN;
            end else begin
                n_phase = gpma_pkg::PH_MOVE1;
            end
        end else if (cmd_done) begin
            n_cmd_valid = 1'b0;
        end else if (out_load) begin
            unique case (r_phase)
                gpma_pkg::PH_TURN:  n_phase = gpma_pkg::PH_MOVE1;
                gpma_pkg::PH_MOVE1: n_phase = gpma_pkg::PH_MOVE2;
                gpma_pkg::PH_MOVE2: n_phase = r_phase;
                gpma_pkg::PH_BAD:   n_phase = r_phase;
            endcase
        end
    end

    // half-cell coordinates
    always_comb begin
        prev2_x = {r_cmd.prev_x, 1'b0};
        prev2_y = {r_cmd.prev_y, 1'b0};
        cell2_x = {r_cmd.cell_x, 1'b0};
        cell2_y = {r_cmd.cell_y, 1'b0};
        mid_x   = {1'b0, r_cmd.prev_x} + {1'b0, r_cmd.cell_x};
        mid_y   = {1'b0, r_cmd.prev_y} + {1'b0, r_cmd.cell_y};
    end

    // sequencer outputs: the word for the current phase
    always_comb begin
        ax = prev2_x;
        ay = prev2_y;
        bx = prev2_x;
        by = prev2_y;
        res = '0;
        res.robot         = r_cmd.robot;
        res.heading       = r_cmd.heading;
        res.start_time    = r_cmd.prev_time;
        res.action_number = r_count;
        unique case (r_phase)
            gpma_pkg::PH_TURN: begin
                res.kind = gpma_pkg::KindTurn;
            end
            gpma_pkg::PH_MOVE1: begin
                res.kind = gpma_pkg::KindMove;
                bx = mid_x;
                by = mid_y;
            end
            gpma_pkg::PH_MOVE2: begin
                res.kind = gpma_pkg::KindMove;
                res.last = 1'b1;
                ax = mid_x;
                ay = mid_y;
                bx = cell2_x;
                by = cell2_y;
            end
            gpma_pkg::PH_BAD: begin
                res.robot         = '0;
                res.heading       = '0;
                res.start_time    = '0;
                res.action_number = '0;
                res.bad_move      = 1'b1;
                res.last          = 1'b1;
                ax = '0;
                ay = '0;
                bx = '0;
                by = '0;
            end
        endcase
        if (i_cfg.flip_axes) begin
            res.from_x = ay;
            res.from_y = ax;
            res.to_x   = by;
            res.to_y   = bx;
        end else begin
            res.from_x = ax;
            res.from_y = ay;
            res.to_x   = bx;
            res.to_y   = by;
        end
    end

    // result register and action counter
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_count     = r_count;
        if (out_load) begin
            n_out       = res;
            n_out_valid = 1'b1;
            if (r_phase != gpma_pkg::PH_BAD) begin
                n_count = r_count + 1'b1;
            end
        end else if (pop_ok) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_phase     <= gpma_pkg::PH_MOVE1;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_cmd_valid <= n_cmd_valid;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

endmodule

### hdl/grid_path_to_motion_actions.sv
// top level of the grid path to motion actions block
// depends on gpma_pkg, gpma_front, gpma_cmd_fifo and gpma_back
//
// Waypoints enter through push/full and are classified in the cycle they are
// taken; actions leave through empty/pop from a result register. A four-deep
// command queue sits between classification and action generation, so the
// waypoint side keeps taking words while results wait to be popped, until the
// queue is full. The action side produces one result word per cycle while
// results are popped: a step with a heading change gives three words, a
// straight step two, a bad jump one; first points, waits and words of a muted
// agent give none. Sustained throughput is thus set by the single result
// register. Configuration writes are always ready and take effect at the next
// edge.
module grid_path_to_motion_actions (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gpma_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic                            i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [gpma_pkg::CoordBits-1:0]  i_cell_x,
    input  logic [gpma_pkg::CoordBits-1:0]  i_cell_y,
    input  logic                            i_starts_agent,
    input  logic [gpma_pkg::RobotBits-1:0]  i_agent_id,
    input  logic [gpma_pkg::TimeBits-1:0]   i_stamp,
    output logic                            empty,
    input  logic                            pop,
    output logic [gpma_pkg::RobotBits-1:0]  o_robot,
    output logic                            o_kind,
    output logic [gpma_pkg::HeadBits-1:0]   o_heading,
    output logic [gpma_pkg::HalfBits-1:0]   o_from_x,
    output logic [gpma_pkg::HalfBits-1:0]   o_from_y,
    output logic [gpma_pkg::HalfBits-1:0]   o_to_x,
    output logic [gpma_pkg::HalfBits-1:0]   o_to_y,
    output logic [gpma_pkg::TimeBits-1:0]   o_start_time,
    output logic [gpma_pkg::NumBits-1:0]    o_action_number,
    output logic                            o_bad_move,
    output logic                            o_last
);

    gpma_pkg::t_cfg    cfg;
    gpma_pkg::t_cmd    wr_cmd, rd_cmd;
    gpma_pkg::t_result result;
    logic              wr_en, rd_en, fifo_full, fifo_empty;

    assign o_cfg_ready = 1'b1;
    assign full        = fifo_full;

    // classification front end
    gpma_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_full         (fifo_full),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_starts_agent (i_starts_agent),
        .i_agent_id     (i_agent_id),
        .i_stamp        (i_stamp),
        .o_cfg          (cfg),
        .o_wr_en        (wr_en),
        .o_wr_cmd       (wr_cmd)
    );

    // command queue
    gpma_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_cmd (wr_cmd),
        .o_full   (fifo_full),
        .i_rd_en  (rd_en),
        .o_rd_cmd (rd_cmd),
        .o_empty  (fifo_empty)
    );

    // action generation back end
    gpma_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_fifo_empty (fifo_empty),
        .i_fifo_cmd   (rd_cmd),
        .o_fifo_rd    (rd_en),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (result)
    );

    // result fields
    assign o_robot         = result.robot;
    assign o_kind          = result.kind;
    assign o_heading       = result.heading;
    assign o_from_x        = result.from_x;
    assign o_from_y        = result.from_y;
    assign o_to_x          = result.to_x;
    assign o_to_y          = result.to_y;
    assign o_start_time    = result.start_time;
    assign o_action_number = result.action_number;
    assign o_bad_move      = result.bad_move;
    assign o_last          = result.last;

endmodule

### dv/tb_grid_path_to_motion_actions.sv
// self-checking testbench for grid_path_to_motion_actions
// depends on gpma_pkg and the block under hdl; a directed route, then random agent walks
// under every flip/timed setting, with random push/pop back-pressure in all but the last phase
`timescale 1ns / 100ps

module tb_grid_path_to_motion_actions;

    localparam int CellMax      = (1 << gpma_pkg::CoordBits) - 1;
    localparam int SettleCycles = 24;
    localparam int WalkWords    = 45;
    localparam int NumPhases    = 5;
    localparam int NumPlanRows  = 21;
    localparam int TimeoutNs    = 4_000_000;

    // one waypoint as it goes on the input ports
    typedef struct packed {
        logic [gpma_pkg::CoordBits-1:0] x;
        logic [gpma_pkg::CoordBits-1:0] y;
        logic                           first;
        logic [gpma_pkg::RobotBits-1:0] id;
        logic [gpma_pkg::TimeBits-1:0]  stamp;
    } t_waypoint;

    // one directed row; typed rows carry the final action word of that waypoint
    typedef struct packed {
        t_waypoint         wp;
        logic              typed;
        gpma_pkg::t_result want;
    } t_plan_row;

    localparam gpma_pkg::t_result NoWord  = '0;
    localparam gpma_pkg::t_result BadWord = '{10'd0, gpma_pkg::KindTurn, 2'd0,
                                              11'd0, 11'd0, 11'd0, 11'd0,
                                              32'd0, 32'd0, 1'b1, 1'b1};

    // directed route, run at the reset settings (no flip, counting time)
    localparam t_plan_row RoutePlan [NumPlanRows] = '{
        // step from the reset cell without a first point
        '{'{10'd1, 10'd0, 1'b0, 10'd5, 32'd0}, 1'b1,
          '{10'd5, gpma_pkg::KindMove, gpma_pkg::HeadYUp, 11'd1, 11'd0, 11'd2, 11'd0,
            32'd0, 32'd2, 1'b0, 1'b1}},
        // new agent in the far corner
        '{'{10'd1023, 10'd1023, 1'b1, 10'd1023, 32'hFFFF_FFFF}, 1'b0, NoWord},
        // straight step, heading already right: two moves only
        '{'{10'd1023, 10'd1022, 1'b0, 10'd1023, 32'd0}, 1'b1,
          '{10'd1023, gpma_pkg::KindMove, gpma_pkg::HeadXDown,
            11'd2046, 11'd2045, 11'd2046, 11'd2044,
            32'd0, 32'd4, 1'b0, 1'b1}},
        // wait, then one step each in three other directions and a second wait
        '{'{10'd1023, 10'd1022, 1'b0, 10'd1023, 32'd0}, 1'b0, NoWord},
        '{'{10'd1022, 10'd1022, 1'b0, 10'd1023, 32'd0}, 1'b0, NoWord},
        '{'{10'd1022, 10'd1023, 1'b0, 10'd1023, 32'd0}, 1'b0, NoWord},
        '{'{10'd1023, 10'd1023, 1'b0, 10'd1023, 32'd0}, 1'b0, NoWord},
        '{'{10'd1023, 10'd1023, 1'b0, 10'd1023, 32'd0}, 1'b0, NoWord},
        // long jump across the grid, then muted words
        '{'{10'd0, 10'd0, 1'b0, 10'd1023, 32'd0}, 1'b1, BadWord},
        '{'{10'd1022, 10'd1023, 1'b0, 10'd1023, 32'd0}, 1'b0, NoWord},
        '{'{10'd1023, 10'd1022, 1'b0, 10'd1023, 32'd0}, 1'b0, NoWord},
        // first point clears the mute; diagonal step is illegal
        '{'{10'd0, 10'd0, 1'b1, 10'd0, 32'd0}, 1'b0, NoWord},
        '{'{10'd1, 10'd1, 1'b0, 10'd0, 32'd0}, 1'b1, BadWord},
        // alternating bit patterns; straight jump of two is illegal
        '{'{10'd512, 10'd512, 1'b1, 10'd341, 32'h5555_5555}, 1'b0, NoWord},
        '{'{10'd512, 10'd513, 1'b0, 10'd682, 32'hAAAA_AAAA}, 1'b0, NoWord},
        '{'{10'd512, 10'd511, 1'b0, 10'd682, 32'd0}, 1'b1, BadWord},
        // walk along the low x border with a full reversal
        '{'{10'd0, 10'd1023, 1'b1, 10'd0, 32'd0}, 1'b0, NoWord},
        '{'{10'd0, 10'd1022, 1'b0, 10'd1, 32'd0}, 1'b0, NoWord},
        '{'{10'd1, 10'd1022, 1'b0, 10'd1, 32'd0}, 1'b0, NoWord},
        '{'{10'd0, 10'd1022, 1'b0, 10'd1, 32'd0}, 1'b0, NoWord},
        '{'{10'd0, 10'd1023, 1'b0, 10'd1, 32'd0}, 1'b0, NoWord}
    };

    localparam bit PhaseFlip  [NumPhases] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam bit PhaseTimed [NumPhases] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_cfg_valid    = 1'b0;
    logic                            o_cfg_ready;
    logic [gpma_pkg::CfgIdxBits-1:0] i_cfg_index    = gpma_pkg::CfgFlipAxes;
    logic                            i_cfg_data     = 1'b0;
    logic                            push           = 1'b0;
    logic                            full;
    logic [gpma_pkg::CoordBits-1:0]  i_cell_x       = '0;
    logic [gpma_pkg::CoordBits-1:0]  i_cell_y       = '0;
    logic                            i_starts_agent = 1'b0;
    logic [gpma_pkg::RobotBits-1:0]  i_agent_id     = '0;
    logic [gpma_pkg::TimeBits-1:0]   i_stamp        = '0;
    logic                            empty;
    logic                            pop            = 1'b0;
    logic [gpma_pkg::RobotBits-1:0]  o_robot;
    logic                            o_kind;
    logic [gpma_pkg::HeadBits-1:0]   o_heading;
    logic [gpma_pkg::HalfBits-1:0]   o_from_x;
    logic [gpma_pkg::HalfBits-1:0]   o_from_y;
    logic [gpma_pkg::HalfBits-1:0]   o_to_x;
    logic [gpma_pkg::HalfBits-1:0]   o_to_y;
    logic [gpma_pkg::TimeBits-1:0]   o_start_time;
    logic [gpma_pkg::NumBits-1:0]    o_action_number;
    logic                            o_bad_move;
    logic                            o_last;

    // mirror of the block's path state and settings
    logic [gpma_pkg::CoordBits-1:0]  path_x       = '0;
    logic [gpma_pkg::CoordBits-1:0]  path_y       = '0;
    logic [gpma_pkg::HeadBits-1:0]   path_heading = '0;
    logic [gpma_pkg::TimeBits-1:0]   path_time    = '0;
    logic [gpma_pkg::NumBits-1:0]    action_seq   = '0;
    logic                            agent_muted  = 1'b0;
    logic                            cfg_flip     = 1'b0;
    logic                            cfg_timed    = 1'b0;

    gpma_pkg::t_result               pending_actions [$];
    int                              mismatches    = 0;
    int                              send_idle_pct = 9;
    int                              recv_idle_pct = 47;
    logic [gpma_pkg::RobotBits-1:0]  walker_id     = '0;

    always #4 i_clk = ~i_clk;

    grid_path_to_motion_actions DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_starts_agent  (i_starts_agent),
        .i_agent_id      (i_agent_id),
        .i_stamp         (i_stamp),
        .empty           (empty),
        .pop             (pop),
        .o_robot         (o_robot),
        .o_kind          (o_kind),
        .o_heading       (o_heading),
        .o_from_x        (o_from_x),
        .o_from_y        (o_from_y),
        .o_to_x          (o_to_x),
        .o_to_y          (o_to_y),
        .o_start_time    (o_start_time),
        .o_action_number (o_action_number),
        .o_bad_move      (o_bad_move),
        .o_last          (o_last)
    );

    // queue one action word, swapping axes when flipped
    function automatic void add_action(input logic [gpma_pkg::RobotBits-1:0] robot,
                                       input logic kind,
                                       input logic [gpma_pkg::HalfBits-1:0] ax, ay, bx, by,
                                       input logic last);
        gpma_pkg::t_result r;
        r               = '0;
        r.robot         = robot;
        r.kind          = kind;
        r.heading       = path_heading;
        r.from_x        = cfg_flip ? ay : ax;
        r.from_y        = cfg_flip ? ax : ay;
        r.to_x          = cfg_flip ? by : bx;
        r.to_y          = cfg_flip ? bx : by;
        r.start_time    = path_time;
        r.action_number = action_seq;
        r.last          = last;
        action_seq      = action_seq + 1'b1;
        pending_actions.insert(pending_actions.size(), r);
    endfunction

    // expected actions for one accepted waypoint
    function automatic void predict_actions(input t_waypoint w);
        int                             dx;
        int                             dy;
        logic [gpma_pkg::TimeBits-1:0]  next_time;
        logic [gpma_pkg::HeadBits-1:0]  need;
        logic [gpma_pkg::HalfBits-1:0]  mid_x;
        logic [gpma_pkg::HalfBits-1:0]  mid_y;
        if (w.first) begin
            path_x       = w.x;
            path_y       = w.y;
            path_heading = gpma_pkg::HeadXDown;
            path_time    = cfg_timed ? w.stamp : '0;
            agent_muted  = 1'b0;
            return;
        end
        if (agent_muted)
            return;
        dx = int'(w.x) - int'(path_x);
        dy = int'(w.y) - int'(path_y);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        // jump of two or more, diagonals too
        if (dx + dy >= 2) begin
            pending_actions.insert(pending_actions.size(), BadWord);
            agent_muted = 1'b1;
            return;
        end
        next_time = cfg_timed ? w.stamp : path_time + 1'b1;
        if (dx + dy == 0) begin
            path_time = next_time;
            return;
        end
        if (dx == 0)
            need = (w.y > path_y) ? gpma_pkg::HeadYUp : gpma_pkg::HeadYDown;
        else
            need = (w.x > path_x) ? gpma_pkg::HeadXUp : gpma_pkg::HeadXDown;
        // unflipped output mirrors the raw heading
        if (!cfg_flip)
            need = 2'd3 - need;
        mid_x = gpma_pkg::HalfBits'(path_x) + gpma_pkg::HalfBits'(w.x);
        mid_y = gpma_pkg::HalfBits'(path_y) + gpma_pkg::HalfBits'(w.y);
        if (need != path_heading) begin
            path_heading = need;
            add_action(w.id, gpma_pkg::KindTurn, {path_x, 1'b0}, {path_y, 1'b0},
                       {path_x, 1'b0}, {path_y, 1'b0}, 1'b0);
        end
        add_action(w.id, gpma_pkg::KindMove, {path_x, 1'b0}, {path_y, 1'b0},
                   mid_x, mid_y, 1'b0);
        add_action(w.id, gpma_pkg::KindMove, mid_x, mid_y, {w.x, 1'b0}, {w.y, 1'b0}, 1'b1);
        path_x    = w.x;
        path_y    = w.y;
        path_time = next_time;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // compare one popped word with the oldest expected action
    function automatic void check_action_word();
        gpma_pkg::t_result got;
        gpma_pkg::t_result want;
        got = '{o_robot, o_kind, o_heading, o_from_x, o_from_y, o_to_x, o_to_y,
                o_start_time, o_action_number, o_bad_move, o_last};
        if (pending_actions.size() == 0) begin
            $error("unexpected action word 0x%0h", got);
            mismatches++;
            return;
        end
        want = pending_actions.pop_front();
        compare_field("robot", 32'(want.robot), 32'(got.robot));
        compare_field("kind", 32'(want.kind), 32'(got.kind));
        compare_field("heading", 32'(want.heading), 32'(got.heading));
        compare_field("from_x", 32'(want.from_x), 32'(got.from_x));
        compare_field("from_y", 32'(want.from_y), 32'(got.from_y));
        compare_field("to_x", 32'(want.to_x), 32'(got.to_x));
        compare_field("to_y", 32'(want.to_y), 32'(got.to_y));
        compare_field("start_time", want.start_time, got.start_time);
        compare_field("action_number", want.action_number, got.action_number);
        compare_field("bad_move", 32'(want.bad_move), 32'(got.bad_move));
        compare_field("last", 32'(want.last), 32'(got.last));
    endfunction

    function automatic int border_or_any();
        case ($urandom_range(3))
            0:       return 0;
            1:       return CellMax;
            default: return $urandom_range(CellMax);
        endcase
    endfunction

    // offer one waypoint after a random gap, predict once accepted
    task automatic send_word(input t_waypoint w);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_cell_x       <= w.x;
        i_cell_y       <= w.y;
        i_starts_agent <= w.first;
        i_agent_id     <= w.id;
        i_stamp        <= w.stamp;
        do
            @(posedge i_clk);
        while (full);
        predict_actions(w);
    endtask

    // wait for all expected words, then let words that cause nothing settle
    task automatic drain_actions();
        while (pending_actions.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_config(input logic flip, input logic timed);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= gpma_pkg::CfgFlipAxes;
        i_cfg_data  <= flip;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_index <= gpma_pkg::CfgTimedMode;
        i_cfg_data  <= timed;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_flip  = flip;
        cfg_timed = timed;
    endtask

    // random agent walks: mostly legal steps, some waits, illegal jumps and muted noise
    task automatic run_walks(input int n_words);
        t_waypoint w;
        int        pick;
        int        px;
        int        py;
        int        nx;
        int        ny;
        int        sx;
        int        sy;
        int        counted;
        counted = 0;
        while (counted < n_words) begin
            pick    = $urandom_range(99);
            px      = int'(path_x);
            py      = int'(path_y);
            nx      = px;
            ny      = py;
            sx      = $urandom_range(1) ? 1 : -1;
            sy      = $urandom_range(1) ? 1 : -1;
            w.first = 1'b0;
            if (pick < 5 || (agent_muted && pick < 60)) begin
                // new agent, often on the grid border
                w.first   = 1'b1;
                nx        = border_or_any();
                ny        = border_or_any();
                walker_id = gpma_pkg::RobotBits'($urandom_range(CellMax));
            end else if (pick < 12) begin
                // wait in place
            end else if (pick < 17) begin
                // illegal jump
                case ($urandom_range(2))
                    0: begin
                        nx = px + sx;
                        ny = py + sy;
                    end
                    1:       nx = px + 2 * sx;
                    default: begin
                        nx = $urandom_range(CellMax);
                        ny = $urandom_range(CellMax);
                    end
                endcase
            end else if ($urandom_range(1)) begin
                nx = px + sx;
            end else begin
                ny = py + sy;
            end
            // fold back off the grid border
            if (nx < 0 || nx > CellMax)
                nx = 2 * px - nx;
            if (ny < 0 || ny > CellMax)
                ny = 2 * py - ny;
            w.x     = gpma_pkg::CoordBits'(nx);
            w.y     = gpma_pkg::CoordBits'(ny);
            w.id    = walker_id;
            w.stamp = $urandom();
            if (w.first || !agent_muted)
                counted++;
            send_word(w);
        end
    endtask

    // result side: random pop, check on every accepted word
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                check_action_word();
            pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #TimeoutNs;
        $display("grid_path_to_motion_actions regression: fail");
        $finish;
    end

    // main sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed route
        for (int i = 0; i < NumPlanRows; i++) begin
            send_word(RoutePlan[i].wp);
            if (RoutePlan[i].typed)
                pending_actions[$] = RoutePlan[i].want;
        end

        // random walks under each setting
        for (int p = 0; p < NumPhases; p++) begin
            push <= 1'b0;
            drain_actions();
            write_config(PhaseFlip[p], PhaseTimed[p]);
            if (p == 2) begin
                send_idle_pct = 47;
                recv_idle_pct = 9;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_walks(WalkWords);
        end

        push <= 1'b0;
        drain_actions();
        if (mismatches == 0)
            $display("grid_path_to_motion_actions regression: pass");
        else
            $display("grid_path_to_motion_actions regression: fail");
        $finish;
    end

endmodule

### files.f
hdl/gpma_pkg.sv
hdl/gpma_front.sv
hdl/gpma_cmd_fifo.sv
hdl/gpma_back.sv
hdl/grid_path_to_motion_actions.sv
dv/tb_grid_path_to_motion_actions.sv
